>>> rtl/arpc_pkg.sv
// Shared types and constants for the ARP cache table.
`timescale 1ns / 1ps
`default_nettype none
package arpc_pkg;

  localparam int ENTRIES_DEF = 256;
  localparam int IP_W        = 32;
  localparam int MAC_W       = 48;
  localparam int AGE_W       = 32;
  localparam int SLOT_W      = 8;

  localparam logic KIND_ADD     = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_in;
    logic [AGE_W-1:0] now_time;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [MAC_W-1:0]  mac_out;
    logic [SLOT_W-1:0] slot;
  } out_t;

  // One table row as stored in the memory.
  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [AGE_W-1:0] age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

>>> rtl/arp_cache_table_top.sv
// ARP cache table: one memory of entries scanned per request, oldest-entry replacement.
//
// Each request (add or resolve) goes from acceptance to the result register as a
// sweep and a write-back: the single read port of the entry RAM is swept over every
// slot, one read per cycle, then the WRITE state writes the chosen slot back (adds
// only) and loads the result. The WRITE state waits while an earlier result is
// still held by out_stall. in_stall is high for the whole request and drops as the
// result is loaded, so a new request is accepted only once the previous one is done.
// Slots are filled from the highest index downward, so a fill counter stands in for
// per-slot valid marks and no clearing pass is needed after reset. A finished
// result waits in the output register while the next request is accepted.
`timescale 1ns / 1ps
`default_nettype none
module arp_cache_table_top #(
  parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire arpc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output arpc_pkg::out_t      out_data
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]              state_r, state_nxt;
  arpc_pkg::in_t           req_r, req_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic [AW-1:0]           addr_r, addr_nxt;
  logic                    issue_r, issue_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]           cmp_idx_r, cmp_idx_nxt;
  logic                    found_r, found_nxt;
  logic [AW-1:0]           match_idx_r, match_idx_nxt;
  logic [arpc_pkg::MAC_W-1:0] match_mac_r, match_mac_nxt;
  logic [arpc_pkg::AGE_W-1:0] min_age_r, min_age_nxt;
  logic [AW-1:0]           min_idx_r, min_idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  arpc_pkg::out_t          out_data_r, out_data_nxt;

  logic                    in_acc;
  logic                    out_free;
  logic                    rd_en;
  logic [arpc_pkg::ENTRY_W-1:0] rd_raw;
  arpc_pkg::entry_t        rd_entry;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  arpc_pkg::entry_t        wr_entry;
  logic                    slot_valid;
  logic                    table_full;
  logic [AW-1:0]           free_idx;
  logic [AW-1:0]           target_idx;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_en    = issue_r;
  assign rd_entry = arpc_pkg::entry_t'(rd_raw);

  // Slots fill from the top, so slot i is in use when i + fill >= ENTRIES.
  assign slot_valid = ({1'b0, cmp_idx_r} + fill_r) >= FULL_CNT;
  assign table_full = (fill_r == FULL_CNT);
  assign free_idx   = AW'(CW'(ENTRIES - 1) - fill_r);
  assign target_idx = found_r ? match_idx_r : (table_full ? min_idx_r : free_idx);

  assign wr_en          = (state_r == ST_WRITE) && out_free
                          && (req_r.kind == arpc_pkg::KIND_ADD);
  assign wr_addr        = target_idx;
  assign wr_entry.ip    = req_r.ip_addr;
  assign wr_entry.mac   = req_r.mac_in;
  assign wr_entry.age   = req_r.now_time;

  arpc_ram #(
    .WIDTH (arpc_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_raw)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    fill_nxt      = fill_r;
    addr_nxt      = addr_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = issue_r;
    cmp_idx_nxt   = addr_r;
    found_nxt     = found_r;
    match_idx_nxt = match_idx_r;
    match_mac_nxt = match_mac_r;
    min_age_nxt   = min_age_r;
    min_idx_nxt   = min_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (issue_r) begin
      if (addr_r == LAST_IDX) begin
        issue_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + AW'(1);
      end
    end

    if (cmp_vld_r) begin
      // lowest matching slot wins
      if (slot_valid && !found_r && rd_entry.ip == req_r.ip_addr) begin
        found_nxt     = 1'b1;
        match_idx_nxt = cmp_idx_r;
        match_mac_nxt = rd_entry.mac;
      end
      // oldest slot, strict compare keeps the lowest index on a tie
      if (cmp_idx_r == '0 || rd_entry.age < min_age_r) begin
        min_age_nxt = rd_entry.age;
        min_idx_nxt = cmp_idx_r;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
          req_nxt   = in_data;
          addr_nxt  = '0;
          issue_nxt = 1'b1;
          found_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (cmp_vld_r && cmp_idx_r == LAST_IDX) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (req_r.kind == arpc_pkg::KIND_RESOLVE) begin
            out_data_nxt.hit     = found_r;
            out_data_nxt.mac_out = found_r ? match_mac_r : '0;
            out_data_nxt.slot    = found_r ? arpc_pkg::SLOT_W'(match_idx_r) : '0;
          end else begin
            out_data_nxt.hit     = found_r;
            out_data_nxt.mac_out = '0;
            out_data_nxt.slot    = arpc_pkg::SLOT_W'(target_idx);
            if (!found_r && !table_full) begin
              fill_nxt = fill_r + CW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    addr_r      <= addr_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    found_r     <= found_nxt;
    match_idx_r <= match_idx_nxt;
    match_mac_r <= match_mac_nxt;
    min_age_r   <= min_age_nxt;
    min_idx_r   <= min_idx_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/arpc_checker.sv
// Port-level checks for the ARP cache table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module arpc_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire arpc_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire arpc_pkg::out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one request at a time: the block is busy right after accepting
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous in flight");

  // only a resolve hit carries a MAC
  a_miss_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.mac_out == '0)
    else $error("MAC reported without a hit");

  // a new result appears only as the request completes
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result issued while request still busy");

endmodule

bind arp_cache_table_top arpc_checker u_arpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

>>> verif/tb_arp_cache_table_top.sv
// Self-checking testbench for the ARP cache table top level.
`timescale 1ns / 1ps
module tb_arp_cache_table_top;

  localparam int TABLE_SIZE       = arpc_pkg::ENTRIES_DEF;
  localparam int IP_W             = arpc_pkg::IP_W;
  localparam int MAC_W            = arpc_pkg::MAC_W;
  localparam int AGE_W            = arpc_pkg::AGE_W;
  localparam int SLOT_W           = arpc_pkg::SLOT_W;
  localparam int POOL_SIZE        = 320;   // more IPs than slots, so the table fills up
  localparam int RANDOM_PER_PHASE = 546;
  localparam int CYCLE_LIMIT      = 3_000_000;

  // Shadow copy of the table; expected results queue up in request order.
  class arp_table_sb;
    bit               slot_used [TABLE_SIZE];
    logic [IP_W-1:0]  slot_ip   [TABLE_SIZE];
    logic [MAC_W-1:0] slot_mac  [TABLE_SIZE];
    logic [AGE_W-1:0] slot_age  [TABLE_SIZE];
    arpc_pkg::out_t   expected_q[$];
    int errors, n_add, n_update, n_evict, n_resolve, n_resolve_hit;

    function new();
      foreach (slot_used[k]) slot_used[k] = 1'b0;
      errors = 0;
      n_add = 0;
      n_update = 0;
      n_evict = 0;
      n_resolve = 0;
      n_resolve_hit = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(arpc_pkg::in_t req);
      int             found_idx;
      int             fill_idx;
      arpc_pkg::out_t exp_res;
      found_idx = -1;
      fill_idx  = -1;
      exp_res   = '0;
      for (int k = 0; k < TABLE_SIZE; k++) begin
        if (slot_used[k] && slot_ip[k] == req.ip_addr) begin
          found_idx = k;
          break;
        end
      end
      if (req.kind == arpc_pkg::KIND_RESOLVE) begin
        n_resolve++;
        if (found_idx >= 0) begin
          n_resolve_hit++;
          exp_res.hit     = 1'b1;
          exp_res.mac_out = slot_mac[found_idx];
          exp_res.slot    = SLOT_W'(found_idx);
        end
      end else begin
        n_add++;
        if (found_idx >= 0) begin
          n_update++;
          slot_mac[found_idx] = req.mac_in;
          slot_age[found_idx] = req.now_time;
          exp_res.hit  = 1'b1;
          exp_res.slot = SLOT_W'(found_idx);
        end else begin
          for (int k = TABLE_SIZE - 1; k >= 0; k--) begin
            if (!slot_used[k]) begin
              fill_idx = k;
              break;
            end
          end
          // Full table: oldest age goes, lowest index on a tie.
          if (fill_idx < 0) begin
            n_evict++;
            fill_idx = 0;
            for (int k = 1; k < TABLE_SIZE; k++)
              if (slot_age[k] < slot_age[fill_idx]) fill_idx = k;
          end
          slot_used[fill_idx] = 1'b1;
          slot_ip[fill_idx]   = req.ip_addr;
          slot_mac[fill_idx]  = req.mac_in;
          slot_age[fill_idx]  = req.now_time;
          exp_res.slot = SLOT_W'(fill_idx);
        end
      end
      expected_q.push_back(exp_res);
    endfunction

    function void report_field(string field, logic [MAC_W-1:0] exp_val,
                               logic [MAC_W-1:0] got_val);
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_val, got_val);
    endfunction

    function void check_result(arpc_pkg::out_t got);
      arpc_pkg::out_t exp_res;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result %h with no request outstanding", $time, got);
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.hit !== exp_res.hit)
        report_field("hit", MAC_W'(exp_res.hit), MAC_W'(got.hit));
      if (got.mac_out !== exp_res.mac_out)
        report_field("mac_out", exp_res.mac_out, got.mac_out);
      if (got.slot !== exp_res.slot)
        report_field("slot", MAC_W'(exp_res.slot), MAC_W'(got.slot));
    endfunction
  endclass

  logic           clk;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  arpc_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  arpc_pkg::out_t out_data;

  arp_table_sb     sb;
  logic [IP_W-1:0] ip_pool [POOL_SIZE];
  int              src_idle_pct;
  int              rcv_idle_pct;
  int              cycle_count;

  arp_cache_table_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic arpc_pkg::in_t make_request(logic kind, logic [IP_W-1:0] ip,
                                                 logic [MAC_W-1:0] mac,
                                                 logic [AGE_W-1:0] now);
    arpc_pkg::in_t req;
    req.kind     = kind;
    req.ip_addr  = ip;
    req.mac_in   = mac;
    req.now_time = now;
    return req;
  endfunction

  function automatic arpc_pkg::in_t make_random_request();
    logic [IP_W-1:0]  ip;
    logic [AGE_W-1:0] now;
    ip = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
    // Small ages make ties common when the table is full.
    case ($urandom_range(0, 9))
      0, 1, 2, 3: now = $urandom_range(0, 7);
      8:          now = '0;
      9:          now = '1;
      default:    now = $urandom;
    endcase
    return make_request(1'($urandom_range(0, 1)), ip, {16'($urandom), 32'($urandom)}, now);
  endfunction

  // Starts and ends right after a rising edge.
  task automatic push_request(arpc_pkg::in_t req);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    sb = new();
    foreach (ip_pool[k]) ip_pool[k] = $urandom;
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    src_idle_pct = 28;
    rcv_idle_pct = 83;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, field extremes, update in place, ignored fields on resolve.
    push_request(make_request(arpc_pkg::KIND_RESOLVE, '0, '0, '0));
    push_request(make_request(arpc_pkg::KIND_RESOLVE, '1, '1, '1));
    push_request(make_request(arpc_pkg::KIND_ADD, '0, '0, '0));
    push_request(make_request(arpc_pkg::KIND_ADD, '1, '1, '1));
    push_request(make_request(arpc_pkg::KIND_RESOLVE, '0, '1, '1));
    push_request(make_request(arpc_pkg::KIND_RESOLVE, '1, '0, '0));
    push_request(make_request(arpc_pkg::KIND_ADD, '1, 48'h0123_4567_89ab, 32'd5));
    push_request(make_request(arpc_pkg::KIND_RESOLVE, '1, '0, '0));
    push_request(make_request(arpc_pkg::KIND_RESOLVE, 32'h1234_5678, 48'hfedc_ba98_7654,
                              32'h8000_0000));
    push_request(make_request(arpc_pkg::KIND_ADD, 32'hc0a8_0001, 48'ha5a5_5a5a_a5a5,
                              32'h8000_0000));
    push_request(make_request(arpc_pkg::KIND_ADD, 32'h8000_0000, 48'h8000_0000_0000,
                              32'h7fff_ffff));
    push_request(make_request(arpc_pkg::KIND_RESOLVE, 32'hc0a8_0001, '0, '0));
    push_request(make_request(arpc_pkg::KIND_RESOLVE, 32'h8000_0000, '0, '0));
    push_request(make_request(arpc_pkg::KIND_ADD, '0, 48'h5a5a_a5a5_5a5a, 32'd1));
    push_request(make_request(arpc_pkg::KIND_RESOLVE, '0, '0, '0));
    wait_for_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 28;
          rcv_idle_pct = 83;
        end
        1: begin
          src_idle_pct = 83;
          rcv_idle_pct = 28;
        end
        default: begin
          src_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) begin
        push_request(make_random_request());
        if ($urandom_range(0, 199) == 0) wait_for_results();
      end
      wait_for_results();
    end

    repeat (TABLE_SIZE + 16) @(posedge clk);

    $display("Adds: %0d (%0d updates, %0d full-table replacements); resolves: %0d (%0d hits).",
             sb.n_add, sb.n_update, sb.n_evict, sb.n_resolve, sb.n_resolve_hit);
    $display("Mismatches: %0d, requests outstanding: %0d.", sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
